// ===== sv/ps2fr_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 frame receiver package
// Shared constants, command and mode codes, and the structs passed between
// the frame core, the byte buffer and the top level.
// ----------------------------------------------------------------------------
package ps2fr_pkg;

    // Byte buffer size and derived widths
    localparam int BUFFER_DEPTH = 16;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 4;
    localparam int BYTE_W  = 8;
    localparam int EDGE_W  = 4;
    localparam int ONES_W  = 4;
    localparam int MODE_W  = 2;

    // Frame edge positions (edge count after increment)
    localparam logic [EDGE_W-1:0] EDGE_DATA_FIRST = 4'd2;
    localparam logic [EDGE_W-1:0] EDGE_DATA_LAST  = 4'd9;
    localparam logic [EDGE_W-1:0] EDGE_PARITY     = 4'd10;
    localparam logic [EDGE_W-1:0] EDGE_STOP       = 4'd11;

    // Mouse packet lengths
    localparam logic [ADDR_W-1:0] MOUSE_LEN_STD = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] MOUSE_LEN_EXT = ADDR_W'(4);

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Receive modes
    localparam logic [MODE_W-1:0] MODE_COMMAND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEYBOARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOUSE    = 2'd2;

    // Configuration register indexes
    localparam logic REG_RECEIVE_MODE   = 1'b0;
    localparam logic REG_EXTENDED_MOUSE = 1'b1;

    // Buffer write request from the frame core
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

    // Status part of one result beat
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               packet_done;
        logic               parity_error;
        logic               inhibit_request;
        logic               frame_ok;
    } status_t;

endpackage

// ===== sv/ps2fr_byte_buffer.sv =====
// ----------------------------------------------------------------------------
// PS/2 frame receiver byte buffer
// Register file for received bytes: one write port from the frame core,
// one registered read port addressed by the read command.
// ----------------------------------------------------------------------------
module ps2fr_byte_buffer
    import ps2fr_pkg::*;
(
    input  logic               clk,
    input  buf_wr_t            wr,
    input  logic               rd_step,
    input  logic               rd_en,
    input  logic [INDEX_W-1:0] rd_index,
    output logic [BYTE_W-1:0]  rd_data
);

    logic [BYTE_W-1:0] mem_reg [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_in_range;

    // Store good bytes
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // Answer zero for other commands and for entries beyond the buffer
    assign rd_in_range = ({1'b0, rd_index} < (INDEX_W + 1)'(BUFFER_DEPTH));

    // Load the read data with the result beat, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (rd_step)
        begin
            if (rd_en && rd_in_range)
            begin
                rd_data_reg <= mem_reg[rd_index[ADDR_W-1:0]];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ps2fr_frame_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 frame receiver core
// Frame assembly, parity check, byte counting and packet completion.
// One command is applied per enabled cycle.
// ----------------------------------------------------------------------------
module ps2fr_frame_core
    import ps2fr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  cmd_t              cmd,
    input  logic              data_bit,
    input  logic [MODE_W-1:0] receive_mode,
    input  logic              extended_mouse,
    output buf_wr_t           buf_wr,
    output status_t           status
);

    logic [EDGE_W-1:0] edge_count_reg, edge_count_next;
    logic [BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic [ONES_W-1:0] ones_count_reg, ones_count_next;
    logic              parity_seen_reg, parity_seen_next;
    logic [ADDR_W-1:0] stored_count_reg, stored_count_next;
    logic              done_flag_reg, done_flag_next;
    logic              error_flag_reg, error_flag_next;

    logic [EDGE_W-1:0] edge_inc;
    logic [BYTE_W-1:0] shift_base;
    logic [ONES_W-1:0] ones_base;
    logic [ADDR_W-1:0] count_inc;
    logic              parity_good;
    logic              complete;
    logic              inhibit;
    logic              ok;

    // Frame start clears the shifter and the ones count
    assign edge_inc    = edge_count_reg + 1'b1;
    assign shift_base  = (edge_count_reg == '0) ? '0 : shift_byte_reg;
    assign ones_base   = (edge_count_reg == '0) ? '0 : ones_count_reg;
    assign parity_good = ones_base[0] ^ parity_seen_reg;
    assign count_inc   = (stored_count_reg < ADDR_W'(BUFFER_DEPTH - 1))
                         ? stored_count_reg + 1'b1 : stored_count_reg;

    // Completion rule per mode, on the updated count
    always_comb
    begin
        case (receive_mode)
            MODE_COMMAND: complete = 1'b1;
            MODE_MOUSE:   complete = (count_inc ==
                                      (extended_mouse ? MOUSE_LEN_EXT : MOUSE_LEN_STD));
            default:      complete = 1'b0;
        endcase
    end

    // Next state for one command
    always_comb
    begin
        edge_count_next   = edge_count_reg;
        shift_byte_next   = shift_byte_reg;
        ones_count_next   = ones_count_reg;
        parity_seen_next  = parity_seen_reg;
        stored_count_next = stored_count_reg;
        done_flag_next    = done_flag_reg;
        error_flag_next   = error_flag_reg;
        buf_wr.en         = 1'b0;
        buf_wr.addr       = stored_count_reg;
        buf_wr.data       = shift_base;
        inhibit           = 1'b0;
        ok                = 1'b0;
        if (step_en)
        begin
            case (cmd)
                CMD_EDGE:
                begin
                    edge_count_next = edge_inc;
                    shift_byte_next = shift_base;
                    ones_count_next = ones_base;
                    if (edge_inc inside {[EDGE_DATA_FIRST:EDGE_DATA_LAST]})
                    begin
                        shift_byte_next = {data_bit, shift_base[BYTE_W-1:1]};
                        ones_count_next = ones_base + ONES_W'(data_bit);
                    end
                    else if (edge_inc == EDGE_PARITY)
                    begin
                        parity_seen_next = data_bit;
                    end
                    else if (edge_inc == EDGE_STOP)
                    begin
                        if (parity_good)
                        begin
                            buf_wr.en         = 1'b1;
                            stored_count_next = count_inc;
                            ok                = 1'b1;
                            if (complete)
                            begin
                                done_flag_next = 1'b1;
                                inhibit        = 1'b1;
                            end
                        end
                        else
                        begin
                            error_flag_next   = 1'b1;
                            stored_count_next = '0;
                        end
                        edge_count_next = '0;
                    end
                end
                CMD_CLEAR:
                begin
                    stored_count_next = '0;
                    done_flag_next    = 1'b0;
                    error_flag_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold frame and status state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg   <= '0;
            shift_byte_reg   <= '0;
            ones_count_reg   <= '0;
            parity_seen_reg  <= 1'b0;
            stored_count_reg <= '0;
            done_flag_reg    <= 1'b0;
            error_flag_reg   <= 1'b0;
        end
        else
        begin
            edge_count_reg   <= edge_count_next;
            shift_byte_reg   <= shift_byte_next;
            ones_count_reg   <= ones_count_next;
            parity_seen_reg  <= parity_seen_next;
            stored_count_reg <= stored_count_next;
            done_flag_reg    <= done_flag_next;
            error_flag_reg   <= error_flag_next;
        end
    end

    // Report status after this command
    assign status.byte_count      = COUNT_W'(stored_count_next);
    assign status.packet_done     = done_flag_next;
    assign status.parity_error    = error_flag_next;
    assign status.inhibit_request = inhibit;
    assign status.frame_ok        = ok;

endmodule

// ===== sv/ps2_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// PS/2 frame receiver unit
// Assembles PS/2 device frames from sampled clock edges, buffers good bytes
// and flags packet completion and parity errors.
// Usage:
//   Slave stream: one beat per command. tuser carries the command (clock
//   falling edge, read buffer entry, clear status); tdata carries the sampled
//   data bit and the buffer index to read.
//   Master stream: exactly one result beat per input beat, in order, with the
//   byte count, sticky done and error flags, the inhibit pulse, the frame-ok
//   mark and the read data (zero unless the beat was a read).
//   Config channel: cfg_index 0 writes the receive mode, 1 the extended mouse
//   select. It is always ready; write it only while the stream is drained.
// Flow: an accepted beat passes through the input register, then the result
//   register; one beat per cycle is sustained while m_axis_tready stays high.
// Reset: frame, count and flags clear, mode returns to mouse, three-byte
//   packets. Buffer contents are undefined until written.
// Stall: while the master side holds tready low, the result register holds and the
//   input register takes at most one more beat and holds it, then s_axis_tready drops; no beat is lost.
// ----------------------------------------------------------------------------
module ps2_frame_receiver_unit
    import ps2fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] data_bit, [4:1] read_index, [7:5] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] byte_count, [4] packet_done,
                                        // [5] parity_error, [6] inhibit_request,
                                        // [7] frame_ok, [15:8] read_data
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    logic               in_valid_reg;
    cmd_t               in_cmd_reg;
    logic               in_bit_reg;
    logic [INDEX_W-1:0] in_index_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;

    logic [MODE_W-1:0]  receive_mode_reg;
    logic               extended_mouse_reg;

    logic               out_advance;
    logic               step_en;
    buf_wr_t            buf_wr;
    status_t            status;
    logic [BYTE_W-1:0]  rd_data;

    // Handshake control
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && out_advance;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_mode_reg   <= MODE_MOUSE;
            extended_mouse_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RECEIVE_MODE:   receive_mode_reg   <= cfg_data;
                REG_EXTENDED_MOUSE: extended_mouse_reg <= cfg_data[0];
                default:            receive_mode_reg   <= receive_mode_reg;
            endcase
        end
    end

    // Input register: take a beat when empty or whenever the core can move on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg   <= cmd_t'(s_axis_tuser);
            in_bit_reg   <= s_axis_tdata[0];
            in_index_reg <= s_axis_tdata[INDEX_W:1];
        end
    end

    // Frame assembly and status
    ps2fr_frame_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .cmd            (in_cmd_reg),
        .data_bit       (in_bit_reg),
        .receive_mode   (receive_mode_reg),
        .extended_mouse (extended_mouse_reg),
        .buf_wr         (buf_wr),
        .status         (status)
    );

    // Received byte storage, read data loaded with the result beat
    ps2fr_byte_buffer u_buffer (
        .clk      (clk),
        .wr       (buf_wr),
        .rd_step  (step_en),
        .rd_en    (in_cmd_reg == CMD_READ),
        .rd_index (in_index_reg),
        .rd_data  (rd_data)
    );

    // Result register: advance when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_status_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {rd_data,
                            out_status_reg.frame_ok,
                            out_status_reg.inhibit_request,
                            out_status_reg.parity_error,
                            out_status_reg.packet_done,
                            out_status_reg.byte_count};

    // An inhibit pulse only comes with a good frame and the done flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[7] && m_axis_tdata[4])
        else $error("inhibit request without good frame or done flag");

    // Input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while result path free");

    // A stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

endmodule
